@@ rtl/core/dhti_pkg.sv @@
`default_nettype none

package dhti_pkg;

   // Field widths of the transfer payloads and of the registers.
   localparam int KEY_W    = 31;
   localparam int SLOT_W   = 7;
   localparam int COLL_W   = 8;
   localparam int STATUS_W = 2;
   localparam int SIZE_W   = 8;
   localparam int PRIME_W  = 7;

   // Remainder unit: a 32-bit dividend, four quotient bits per iteration.
   localparam int DIV_W       = 32;
   localparam int DIGIT_W     = 4;
   localparam int REM_W       = 8;
   localparam int CNT_W       = 3;
   localparam int KEY_PASSES  = DIV_W / DIGIT_W;
   localparam int STEP_PASSES = REM_W / DIGIT_W;

   // Register indexes on the configuration port.
   localparam logic CSR_TABLE_SIZE = 1'b0;
   localparam logic CSR_STEP_PRIME = 1'b1;

   typedef enum logic [STATUS_W-1:0] {
      ST_INSERTED = 2'd0,
      ST_FULL     = 2'd1,
      ST_READ     = 2'd2
   } status_type;

   typedef enum logic [3:0] {
      OP_NOP,
      OP_CLEAR,
      OP_IDLE,
      OP_DISPATCH,
      OP_REM_ITER,
      OP_LOAD_STEP,
      OP_PROBE_INIT,
      OP_PROBE_RD,
      OP_PROBE_CHK,
      OP_RESP_FULL,
      OP_RESP_INSERT,
      OP_READ_RD,
      OP_RESP_READ
   } op_type;

   typedef enum logic [2:0] {
      COND_NEVER,
      COND_ALWAYS,
      COND_NOT_START,
      COND_IS_READ,
      COND_REM_MORE,
      COND_SLOT_FREE,
      COND_PROBE_MORE,
      COND_CLR_MORE
   } cond_type;

   typedef logic [3:0] pc_type;

   typedef struct packed {
      op_type   op;
      cond_type cond;
      pc_type   target;
   } ctrl_word_type;

   typedef struct packed {
      logic start;
      logic is_read;
      logic rem_more;
      logic slot_free;
      logic probe_more;
      logic clr_more;
   } cond_flags_type;

   localparam pc_type PC_CLEAR      = 4'd0;
   localparam pc_type PC_IDLE       = 4'd1;
   localparam pc_type PC_DISPATCH   = 4'd2;
   localparam pc_type PC_REM_KEY    = 4'd3;
   localparam pc_type PC_LOAD_STEP  = 4'd4;
   localparam pc_type PC_REM_STEP   = 4'd5;
   localparam pc_type PC_PROBE_INIT = 4'd6;
   localparam pc_type PC_PROBE_RD   = 4'd7;
   localparam pc_type PC_PROBE_CHK  = 4'd8;
   localparam pc_type PC_PROBE_NEXT = 4'd9;
   localparam pc_type PC_RESP_FULL  = 4'd10;
   localparam pc_type PC_RESP_INS   = 4'd11;
   localparam pc_type PC_READ_RD    = 4'd12;
   localparam pc_type PC_RESP_READ  = 4'd13;

   // Control store. The jump is taken when the condition holds, otherwise
   // the program falls through to the next step.
   function automatic ctrl_word_type ucode_rom(input pc_type pc);
      ctrl_word_type w;
      begin
         unique case (pc)
            PC_CLEAR:      w = '{OP_CLEAR,       COND_CLR_MORE,   PC_CLEAR};
            PC_IDLE:       w = '{OP_IDLE,        COND_NOT_START,  PC_IDLE};
            PC_DISPATCH:   w = '{OP_DISPATCH,    COND_IS_READ,    PC_READ_RD};
            PC_REM_KEY:    w = '{OP_REM_ITER,    COND_REM_MORE,   PC_REM_KEY};
            PC_LOAD_STEP:  w = '{OP_LOAD_STEP,   COND_NEVER,      PC_IDLE};
            PC_REM_STEP:   w = '{OP_REM_ITER,    COND_REM_MORE,   PC_REM_STEP};
            PC_PROBE_INIT: w = '{OP_PROBE_INIT,  COND_NEVER,      PC_IDLE};
            PC_PROBE_RD:   w = '{OP_PROBE_RD,    COND_NEVER,      PC_IDLE};
            PC_PROBE_CHK:  w = '{OP_PROBE_CHK,   COND_SLOT_FREE,  PC_RESP_INS};
            PC_PROBE_NEXT: w = '{OP_NOP,         COND_PROBE_MORE, PC_PROBE_RD};
            PC_RESP_FULL:  w = '{OP_RESP_FULL,   COND_ALWAYS,     PC_IDLE};
            PC_RESP_INS:   w = '{OP_RESP_INSERT, COND_ALWAYS,     PC_IDLE};
            PC_READ_RD:    w = '{OP_READ_RD,     COND_NEVER,      PC_IDLE};
            PC_RESP_READ:  w = '{OP_RESP_READ,   COND_ALWAYS,     PC_IDLE};
            default:       w = '{OP_NOP,         COND_ALWAYS,     PC_IDLE};
         endcase
         return w;
      end
   endfunction

   // Four steps of restoring division; only the remainder is kept.
   function automatic logic [REM_W-1:0] rem_digit(input logic [REM_W-1:0]   r,
                                                  input logic [DIGIT_W-1:0] bits,
                                                  input logic [REM_W-1:0]   d);
      logic [REM_W:0]   t;
      logic [REM_W-1:0] acc;
      begin
         acc = r;
         for (int j = DIGIT_W - 1; j >= 0; j--) begin
            t = {acc, bits[j]};
            if (t >= {1'b0, d}) begin
               t = t - {1'b0, d};
            end
            acc = t[REM_W-1:0];
         end
         return acc;
      end
   endfunction

endpackage

`default_nettype wire

@@ rtl/core/dhti_seq.sv @@
`default_nettype none

module dhti_seq (
   input  logic                     clock,
   input  logic                     reset,
   input  dhti_pkg::cond_flags_type flags,
   output dhti_pkg::ctrl_word_type  ctrl
);
   import dhti_pkg::*;

   pc_type pc_ff;
   pc_type pc_in;
   logic   jump;

   assign ctrl = ucode_rom(pc_ff);

   always_comb begin
      unique case (ctrl.cond)
         COND_NEVER:      jump = 1'b0;
         COND_ALWAYS:     jump = 1'b1;
         COND_NOT_START:  jump = !flags.start;
         COND_IS_READ:    jump = flags.is_read;
         COND_REM_MORE:   jump = flags.rem_more;
         COND_SLOT_FREE:  jump = flags.slot_free;
         COND_PROBE_MORE: jump = flags.probe_more;
         COND_CLR_MORE:   jump = flags.clr_more;
         default:         jump = 1'b0;
      endcase
      pc_in = jump ? ctrl.target : pc_type'(pc_ff + 4'd1);
   end

   // Reset starts the program at the clearing pass.
   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= PC_CLEAR;
      end else begin
         pc_ff <= pc_in;
      end
   end

endmodule

`default_nettype wire

@@ rtl/core/double_hash_table_insert_top.sv @@
`default_nettype none

// Open-addressed hash table with double hashing, insert and slot read.
// Command channel: an item transfers on a rising edge with start high and
// busy low. req_func selects insert of req_key (0) or read of req_read_slot
// (1). One result follows each item as a one-cycle strobe on rsp_valid with
// rsp_status, rsp_slot_index, rsp_collisions and rsp_slot_value; the
// receiver cannot stall, so the result is simply presented and dropped.
// Items run one at a time under a microcoded sequencer, with busy high
// until the result has been issued.
// A read runs through dispatch, the slot read and the result step. An insert
// computes key mod m and key mod p (four bits a cycle in one remainder
// unit), reduces the step mod m, then probes through the single-port slot
// memory with a read, a check and a next step per probe, until it finds a
// free slot or has seen m collisions. Busy drops as the strobe goes out, so
// the next command can transfer at the edge that ends the strobe.
// Reset restores table_size 127 and step_prime 113 and then runs a clearing
// pass over all TABLE_DEPTH slots of the slot memory; busy stays high during
// it. Configuration writes on the csr_ port take effect at once; they may
// land during the clearing pass but must not change while a command is busy.
module double_hash_table_insert_top #(
   parameter int TABLE_DEPTH = 128
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   output logic                           busy,
   input  logic                           req_func,
   input  logic [dhti_pkg::KEY_W-1:0]     req_key,
   input  logic [dhti_pkg::SLOT_W-1:0]    req_read_slot,
   output logic                           rsp_valid,
   output logic [dhti_pkg::STATUS_W-1:0]  rsp_status,
   output logic [dhti_pkg::SLOT_W-1:0]    rsp_slot_index,
   output logic [dhti_pkg::COLL_W-1:0]    rsp_collisions,
   output logic [dhti_pkg::KEY_W-1:0]     rsp_slot_value,
   input  logic                           csr_write_en,
   input  logic                           csr_index,
   input  logic [dhti_pkg::SIZE_W-1:0]    csr_wdata
);
   import dhti_pkg::*;

   localparam int AW = $clog2(TABLE_DEPTH);

   ctrl_word_type  ctrl;
   cond_flags_type flags;

   // Configuration registers.
   logic [SIZE_W-1:0]  table_size_ff;
   logic [PRIME_W-1:0] step_prime_ff;
   logic [REM_W-1:0]   m_eff;
   logic [REM_W-1:0]   p_eff;

   // Item and datapath registers.
   logic               func_ff,   func_in;
   logic [KEY_W-1:0]   key_ff,    key_in;
   logic [SLOT_W-1:0]  rslot_ff,  rslot_in;
   logic [DIV_W-1:0]   div_ff,    div_in;
   logic [REM_W-1:0]   rem_m_ff,  rem_m_in;
   logic [REM_W-1:0]   rem_p_ff,  rem_p_in;
   logic [CNT_W-1:0]   cnt_ff,    cnt_in;
   logic [REM_W-1:0]   base_ff,   base_in;
   logic [REM_W-1:0]   step_ff,   step_in;
   logic [REM_W-1:0]   slot_ff,   slot_in;
   logic [COLL_W-1:0]  coll_ff,   coll_in;
   logic               rd_ok_ff,  rd_ok_in;
   logic [AW-1:0]      clr_ff,    clr_in;
   logic [REM_W:0]     slot_sum;

   // Result registers.
   logic               rsp_valid_ff,  rsp_valid_in;
   status_type         rsp_status_ff, rsp_status_in;
   logic [SLOT_W-1:0]  rsp_slot_ff,   rsp_slot_in;
   logic [COLL_W-1:0]  rsp_coll_ff,   rsp_coll_in;
   logic [KEY_W-1:0]   rsp_value_ff,  rsp_value_in;

   // Slot memory.
   logic [KEY_W-1:0]   slot_mem [TABLE_DEPTH];
   logic [KEY_W-1:0]   rdata_ff;
   logic               mem_we;
   logic               mem_re;
   logic [AW-1:0]      mem_addr;
   logic [KEY_W-1:0]   mem_wdata;

   dhti_seq u_seq (
      .clock (clock),
      .reset (reset),
      .flags (flags),
      .ctrl  (ctrl)
   );

   assign busy = (ctrl.op != OP_IDLE);

   // A size of zero acts as one, and the size never exceeds the memory.
   always_comb begin
      m_eff = table_size_ff;
      if (table_size_ff == '0) begin
         m_eff = REM_W'(1);
      end
      if (32'(table_size_ff) > TABLE_DEPTH) begin
         m_eff = REM_W'(TABLE_DEPTH);
      end
      p_eff = (step_prime_ff == '0) ? REM_W'(1) : {1'b0, step_prime_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         table_size_ff <= SIZE_W'(127);
         step_prime_ff <= PRIME_W'(113);
      end else if (csr_write_en) begin
         unique case (csr_index)
            CSR_TABLE_SIZE: table_size_ff <= csr_wdata;
            CSR_STEP_PRIME: step_prime_ff <= csr_wdata[PRIME_W-1:0];
            default:        table_size_ff <= table_size_ff;
         endcase
      end
   end

   always_comb begin
      flags.start      = start;
      flags.is_read    = func_ff;
      flags.rem_more   = (cnt_ff != '0);
      flags.slot_free  = (rdata_ff == '0);
      flags.probe_more = (coll_ff != m_eff);
      flags.clr_more   = (clr_ff != AW'(TABLE_DEPTH - 1));
   end

   always_comb begin
      slot_sum = {1'b0, slot_ff} + {1'b0, step_ff};
      if (slot_sum >= {1'b0, m_eff}) begin
         slot_sum = slot_sum - {1'b0, m_eff};
      end
   end

   always_comb begin
      func_in       = func_ff;
      key_in        = key_ff;
      rslot_in      = rslot_ff;
      div_in        = div_ff;
      rem_m_in      = rem_m_ff;
      rem_p_in      = rem_p_ff;
      cnt_in        = cnt_ff;
      base_in       = base_ff;
      step_in       = step_ff;
      slot_in       = slot_ff;
      coll_in       = coll_ff;
      rd_ok_in      = rd_ok_ff;
      clr_in        = clr_ff;
      rsp_valid_in  = 1'b0;
      rsp_status_in = rsp_status_ff;
      rsp_slot_in   = rsp_slot_ff;
      rsp_coll_in   = rsp_coll_ff;
      rsp_value_in  = rsp_value_ff;
      mem_we        = 1'b0;
      mem_re        = 1'b0;
      mem_addr      = '0;
      mem_wdata     = '0;

      unique case (ctrl.op)
         OP_CLEAR: begin
            mem_we   = 1'b1;
            mem_addr = clr_ff;
            clr_in   = clr_ff + AW'(1);
         end
         OP_IDLE: begin
            if (start) begin
               func_in  = req_func;
               key_in   = req_key;
               rslot_in = req_read_slot;
               div_in   = {1'b0, req_key};
               rem_m_in = '0;
               rem_p_in = '0;
               cnt_in   = CNT_W'(KEY_PASSES - 1);
            end
         end
         OP_REM_ITER: begin
            rem_m_in = rem_digit(rem_m_ff, div_ff[DIV_W-1 -: DIGIT_W], m_eff);
            rem_p_in = rem_digit(rem_p_ff, div_ff[DIV_W-1 -: DIGIT_W], p_eff);
            div_in   = {div_ff[DIV_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
            cnt_in   = cnt_ff - CNT_W'(1);
         end
         OP_LOAD_STEP: begin
            // The second hash is reduced mod m so one subtract keeps the
            // probe position in range.
            base_in  = rem_m_ff;
            div_in   = {rem_p_ff + REM_W'(1), {(DIV_W - REM_W){1'b0}}};
            rem_m_in = '0;
            rem_p_in = '0;
            cnt_in   = CNT_W'(STEP_PASSES - 1);
         end
         OP_PROBE_INIT: begin
            step_in = rem_m_ff;
            slot_in = base_ff;
            coll_in = '0;
         end
         OP_PROBE_RD: begin
            mem_re   = 1'b1;
            mem_addr = AW'(slot_ff);
         end
         OP_PROBE_CHK: begin
            if (rdata_ff != '0) begin
               coll_in = coll_ff + COLL_W'(1);
               slot_in = slot_sum[REM_W-1:0];
            end
         end
         OP_RESP_FULL: begin
            rsp_valid_in  = 1'b1;
            rsp_status_in = ST_FULL;
            rsp_slot_in   = '0;
            rsp_coll_in   = coll_ff;
            rsp_value_in  = '0;
         end
         OP_RESP_INSERT: begin
            mem_we        = 1'b1;
            mem_addr      = AW'(slot_ff);
            mem_wdata     = key_ff;
            rsp_valid_in  = 1'b1;
            rsp_status_in = ST_INSERTED;
            rsp_slot_in   = slot_ff[SLOT_W-1:0];
            rsp_coll_in   = coll_ff;
            rsp_value_in  = '0;
         end
         OP_READ_RD: begin
            mem_re   = 1'b1;
            mem_addr = AW'(rslot_ff);
            rd_ok_in = (32'(rslot_ff) < TABLE_DEPTH);
         end
         OP_RESP_READ: begin
            rsp_valid_in  = 1'b1;
            rsp_status_in = ST_READ;
            rsp_slot_in   = rslot_ff;
            rsp_coll_in   = '0;
            rsp_value_in  = rd_ok_ff ? rdata_ff : '0;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         slot_mem[mem_addr] <= mem_wdata;
      end
      if (mem_re) begin
         rdata_ff <= slot_mem[mem_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      func_ff       <= func_in;
      key_ff        <= key_in;
      rslot_ff      <= rslot_in;
      div_ff        <= div_in;
      rem_m_ff      <= rem_m_in;
      rem_p_ff      <= rem_p_in;
      cnt_ff        <= cnt_in;
      base_ff       <= base_in;
      step_ff       <= step_in;
      slot_ff       <= slot_in;
      coll_ff       <= coll_in;
      rd_ok_ff      <= rd_ok_in;
      rsp_status_ff <= rsp_status_in;
      rsp_slot_ff   <= rsp_slot_in;
      rsp_coll_ff   <= rsp_coll_in;
      rsp_value_ff  <= rsp_value_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_slot_index = rsp_slot_ff;
   assign rsp_collisions = rsp_coll_ff;
   assign rsp_slot_value = rsp_value_ff;

   // An accepted command always starts the program.
   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("command transfer did not start the sequencer");

   // A result only follows a cycle in which a command was in work.
   a_rsp_after_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy))
      else $error("result strobe without a command in work");

   // Result strobes never come back to back, so each one stays a single pulse.
   a_rsp_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe lasted more than one cycle");

   // The probe counter never passes the table size during a probe.
   a_coll_bound: assert property (@(posedge clock) disable iff (reset)
      (ctrl.op == OP_PROBE_CHK) |-> (coll_ff < m_eff))
      else $error("probe count ran past the table size");

endmodule

`default_nettype wire
